// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

	localparam int CHAR_W    = 8;
	localparam int IDX_W     = 11;
	localparam int DATA_W    = 16;
	localparam int COLOR_W   = 4;
	localparam int ATTR_W    = 2 * COLOR_W;
	localparam int COL_OUT_W = 7;
	localparam int ROW_OUT_W = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CHAR_W-1:0]  CHAR_BS    = 8'h08;
	localparam logic [CHAR_W-1:0]  CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0]  CHAR_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0]  CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0]  CHAR_BLANK = 8'h20;
	localparam logic [DATA_W-1:0]  RESET_CELL = 16'h0F20;
	localparam logic [COLOR_W-1:0] FG_RESET   = 4'hF;
	localparam logic [COLOR_W-1:0] BG_RESET   = 4'h0;

	typedef enum logic {
		OP_PUT  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FG = 1'b0,
		CFG_BG = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUT,
		ST_ROW,
		ST_SCROLL,
		ST_DRAIN,
		ST_READ,
		ST_RDATA,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [COL_OUT_W-1:0] cursor_col;
		logic [ROW_OUT_W-1:0] cursor_row;
		logic [DATA_W-1:0]    cell_data;
		logic                 scrolled;
	} rsp_t;

endpackage

// ===== rtl/tcw_in_if.sv =====
interface tcw_in_if import tcw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             op;
	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  cell_index;

	modport source (output valid, output op, output char_code, output cell_index, input ready);
	modport sink (input valid, input op, input char_code, input cell_index, output ready);
endinterface

// ===== rtl/tcw_out_if.sv =====
interface tcw_out_if import tcw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [COL_OUT_W-1:0] cursor_col;
	logic [ROW_OUT_W-1:0] cursor_row;
	logic [DATA_W-1:0]    cell_data;
	logic                 scrolled;

	modport source (output valid, output cursor_col, output cursor_row, output cell_data,
		output scrolled, input ready);
	modport sink (input valid, input cursor_col, input cursor_row, input cell_data,
		input scrolled, output ready);
endinterface

// ===== rtl/tcw_cfg_if.sv =====
interface tcw_cfg_if import tcw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COLOR_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tcw_ram.sv =====
module tcw_ram import tcw_pkg::*; #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tcw_ctrl.sv =====
module tcw_ctrl import tcw_pkg::*; #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	tcw_in_if.sink            req,
	input  logic [ATTR_W-1:0] attr,
	input  logic              res_ready,
	output logic              res_valid,
	output rsp_t              res
);

	localparam int CELLS   = ROWS * COLUMNS;
	localparam int CELL_W  = $clog2(CELLS);
	localparam int ADD_W   = $clog2(CELLS + COLUMNS);
	localparam int COL_W   = $clog2(COLUMNS + TAB_STOP);
	localparam int ROW_W   = $clog2(ROWS);
	localparam int PHASE_W = $clog2(TAB_STOP);

	state_t              state_q, state_d;
	logic [CELL_W-1:0]   ptr_q, ptr_d;
	logic [CELL_W-1:0]   base_q, base_d;
	logic [COL_W-1:0]    col_q, col_d;
	logic [ROW_W-1:0]    row_q, row_d;
	logic [PHASE_W-1:0]  phase_q, phase_d;
	logic [CHAR_W-1:0]   ch_q, ch_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic [DATA_W-1:0]   data_q, data_d;
	logic                scrolled_q, scrolled_d;
	logic                wr_s1;
	logic [CELL_W-1:0]   dst_s1;
	logic                blank_s1;

	logic [ADD_W-1:0]    add_a, add_b, sum;
	logic                we;
	logic [CELL_W-1:0]   waddr, raddr;
	logic [DATA_W-1:0]   wdata, rdata;
	logic [DATA_W-1:0]   blank_cell;

	assign blank_cell = {attr, CHAR_BLANK};

	// shared address adder
	assign sum = add_a + add_b;

	tcw_ram #(
		.DEPTH(CELLS),
		.AW   (CELL_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			ptr_q    <= '0;
			base_q   <= '0;
			col_q    <= '0;
			row_q    <= '0;
			phase_q  <= '0;
			wr_s1    <= 1'b0;
		end else begin
			state_q  <= state_d;
			ptr_q    <= ptr_d;
			base_q   <= base_d;
			col_q    <= col_d;
			row_q    <= row_d;
			phase_q  <= phase_d;
			wr_s1    <= (state_q == ST_SCROLL);
		end
	end

	always_ff @(posedge clk) begin
		ch_q       <= ch_d;
		idx_q      <= idx_d;
		data_q     <= data_d;
		scrolled_q <= scrolled_d;
		dst_s1     <= ptr_q;
		blank_s1   <= (sum >= ADD_W'(CELLS));
	end

	always_comb begin
		logic row_inc;
		logic op_read;

		state_d    = state_q;
		ptr_d      = ptr_q;
		base_d     = base_q;
		col_d      = col_q;
		row_d      = row_q;
		phase_d    = phase_q;
		ch_d       = ch_q;
		idx_d      = idx_q;
		data_d     = data_q;
		scrolled_d = scrolled_q;
		add_a      = '0;
		add_b      = '0;
		we         = 1'b0;
		waddr      = ptr_q;
		wdata      = RESET_CELL;
		raddr      = ptr_q;
		req.ready  = 1'b0;
		res_valid  = 1'b0;
		row_inc    = 1'b0;
		op_read    = (req.op == OP_READ);

		case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				ptr_d = ptr_q + 1'b1;
				if (ptr_q == CELL_W'(CELLS - 1)) begin
					ptr_d   = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					ch_d       = req.char_code;
					idx_d      = req.cell_index;
					data_d     = '0;
					scrolled_d = 1'b0;
					state_d    = op_read ? ST_READ : ST_PUT;
				end
			end
			ST_PUT: begin
				add_a = ADD_W'(base_q);
				add_b = ADD_W'(col_q);
				case (ch_q)
					CHAR_BS: begin
						if (col_q != '0) begin
							col_d   = col_q - 1'b1;
							phase_d = (phase_q == '0) ? PHASE_W'(TAB_STOP - 1) : phase_q - 1'b1;
						end
					end
					CHAR_TAB: begin
						col_d   = col_q + COL_W'(TAB_STOP) - COL_W'(phase_q);
						phase_d = '0;
					end
					CHAR_CR: begin
						col_d   = '0;
						phase_d = '0;
					end
					CHAR_LF: begin
						col_d   = '0;
						phase_d = '0;
						row_inc = 1'b1;
					end
					default: begin
						if (ch_q >= CHAR_BLANK) begin
							we      = 1'b1;
							waddr   = CELL_W'(sum);
							wdata   = {attr, ch_q};
							col_d   = col_q + 1'b1;
							phase_d = (phase_q == PHASE_W'(TAB_STOP - 1)) ? '0 : phase_q + 1'b1;
						end
					end
				endcase
				// right margin wrap
				if (col_d >= COL_W'(COLUMNS)) begin
					col_d   = '0;
					phase_d = '0;
					row_inc = 1'b1;
				end
				state_d = row_inc ? ST_ROW : ST_DONE;
			end
			ST_ROW: begin
				add_a = ADD_W'(base_q);
				add_b = ADD_W'(COLUMNS);
				if (row_q == ROW_W'(ROWS - 1)) begin
					ptr_d      = '0;
					scrolled_d = 1'b1;
					state_d    = ST_SCROLL;
				end else begin
					row_d   = row_q + 1'b1;
					base_d  = CELL_W'(sum);
					state_d = ST_DONE;
				end
			end
			ST_SCROLL: begin
				add_a = ADD_W'(ptr_q);
				add_b = ADD_W'(COLUMNS);
				raddr = CELL_W'(sum);
				ptr_d = ptr_q + 1'b1;
				if (ptr_q == CELL_W'(CELLS - 1)) begin
					ptr_d   = '0;
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_READ: begin
				raddr   = CELL_W'(idx_q);
				state_d = ST_RDATA;
			end
			ST_RDATA: begin
				data_d  = (32'(idx_q) < 32'(CELLS)) ? rdata : '0;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// scroll copy write stage
		if (wr_s1) begin
			we    = 1'b1;
			waddr = dst_s1;
			wdata = blank_s1 ? blank_cell : rdata;
		end
	end

	assign res.cursor_col = COL_OUT_W'(col_q);
	assign res.cursor_row = ROW_OUT_W'(row_q);
	assign res.cell_data  = data_q;
	assign res.scrolled   = scrolled_q;

endmodule

// ===== rtl/text_console_char_writer.sv =====
// path from request to result valid: a read goes through ST_READ and ST_RDATA, a put
// through ST_PUT, one that moves to the next line also via ST_ROW, one that scrolls
// also via ST_ROW, ST_SCROLL and ST_DRAIN; one request at a time, the next once results
// drain; the scroll copy moves one cell per cycle over the memory's read and write ports
// reset: cursor to home, colors white on black, then a clearing pass fills the screen
// with blanks; requests wait, config writes are taken at once
module text_console_char_writer import tcw_pkg::*; #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	tcw_in_if.sink     req,
	tcw_out_if.source  rsp,
	tcw_cfg_if.sink    cfg
);

	logic [COLOR_W-1:0] fg_q, bg_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic               res_valid;
	logic               res_ready;
	rsp_t               res;

	assign cfg.ready = 1'b1;
	assign res_ready = !rsp_valid_q || rsp.ready;

	tcw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.TAB_STOP(TAB_STOP)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.attr     ({bg_q, fg_q}),
		.res_ready(res_ready),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_FG: fg_q <= cfg.data;
				CFG_BG: bg_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.cursor_col = rsp_q.cursor_col;
	assign rsp.cursor_row = rsp_q.cursor_row;
	assign rsp.cell_data  = rsp_q.cell_data;
	assign rsp.scrolled   = rsp_q.scrolled;

endmodule

// ===== test/text_console_char_writer_tb.sv =====
`timescale 1ns / 100ps

module text_console_char_writer_tb import tcw_pkg::*;;

	localparam int COLUMNS       = 80;
	localparam int ROWS          = 25;
	localparam int TAB_STOP      = 8;
	localparam int CELLS         = ROWS * COLUMNS;
	localparam int IDX_MAX       = (1 << IDX_W) - 1;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 20000;
	localparam int HOLD_CYCLES   = 3000;
	localparam int RANDOM_ITEMS  = 475;

	logic clk;
	logic arst_n;

	tcw_in_if  req_if ();
	tcw_out_if rsp_if ();
	tcw_cfg_if cfg_if ();

	text_console_char_writer #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	logic [DATA_W-1:0]  screen_model [CELLS];
	int unsigned        col_model;
	int unsigned        row_model;
	logic [COLOR_W-1:0] fg_model;
	logic [COLOR_W-1:0] bg_model;
	rsp_t               predicted_rsp [$];
	int                 mismatch_count;
	int                 src_idle_pct;
	int                 snk_stall_pct;
	int                 hold_len;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic rsp_t console_step(logic op, logic [CHAR_W-1:0] ch,
		logic [IDX_W-1:0] idx);
		rsp_t             r;
		int unsigned      pos;
		int               k;
		logic [ATTR_W-1:0] attr;
		r = '0;
		attr = {bg_model, fg_model};
		if (op == OP_READ) begin
			if (idx < CELLS)
				r.cell_data = screen_model[idx];
		end else begin
			case (ch)
				CHAR_BS: begin
					if (col_model != 0)
						col_model--;
				end
				CHAR_TAB: col_model = (col_model / TAB_STOP + 1) * TAB_STOP;
				CHAR_CR: col_model = 0;
				CHAR_LF: begin
					col_model = 0;
					row_model++;
				end
				default: begin
					if (ch >= CHAR_BLANK) begin
						pos = row_model * COLUMNS + col_model;
						if (pos < CELLS)
							screen_model[pos] = {attr, ch};
						col_model++;
					end
				end
			endcase
			if (col_model >= COLUMNS) begin
				col_model = 0;
				row_model++;
			end
			if (row_model >= ROWS) begin
				for (k = 0; k < CELLS - COLUMNS; k++)
					screen_model[k] = screen_model[k + COLUMNS];
				for (k = CELLS - COLUMNS; k < CELLS; k++)
					screen_model[k] = {attr, CHAR_BLANK};
				row_model = ROWS - 1;
				r.scrolled = 1'b1;
			end
		end
		r.cursor_col = COL_OUT_W'(col_model);
		r.cursor_row = ROW_OUT_W'(row_model);
		return r;
	endfunction

	task automatic flag_mismatch(string what);
		mismatch_count++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	task automatic check_field(string name, int got, int want);
		if (got != want)
			flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// prediction, config tracking and result checking
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_if.index)
					CFG_FG: fg_model = cfg_if.data;
					CFG_BG: bg_model = cfg_if.data;
					default: ;
				endcase
			end
			if (req_if.valid && req_if.ready)
				predicted_rsp.push_back(console_step(req_if.op, req_if.char_code,
					req_if.cell_index));
			if (rsp_if.valid && rsp_if.ready) begin
				if (predicted_rsp.size() == 0) begin
					flag_mismatch("result with no request pending");
				end else begin
					want = predicted_rsp.pop_front();
					check_field("cursor_col", rsp_if.cursor_col, want.cursor_col);
					check_field("cursor_row", rsp_if.cursor_row, want.cursor_row);
					check_field("cell_data", rsp_if.cell_data, want.cell_data);
					check_field("scrolled", rsp_if.scrolled, want.scrolled);
				end
			end
		end
	end

	// result side ready, with random stalls and long hold-offs
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				rsp_if.ready <= 1'b0;
				hold_len--;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic set_idling(int src_pct, int snk_pct);
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
	endtask

	task automatic send_item(op_t op, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.op <= op;
		req_if.char_code <= ch;
		req_if.cell_index <= idx;
		do
			@(posedge clk);
		while (!req_if.ready);
		@(negedge clk);
	endtask

	task automatic stop_sending();
		req_if.valid <= 1'b0;
	endtask

	task automatic put_char(logic [CHAR_W-1:0] ch);
		send_item(OP_PUT, ch, IDX_W'($urandom));
	endtask

	task automatic read_cell(logic [IDX_W-1:0] idx);
		send_item(OP_READ, CHAR_W'($urandom), idx);
	endtask

	task automatic wait_drained();
		while (predicted_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [COLOR_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_colors(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
		wait_drained();
		write_reg(CFG_FG, fg);
		write_reg(CFG_BG, bg);
	endtask

	task automatic test_reset_screen();
		read_cell(0);
		read_cell(CELLS - 1);
		read_cell(CELLS);
		read_cell(IDX_MAX);
		stop_sending();
	endtask

	task automatic test_printables();
		put_char(CHAR_BLANK);
		put_char(8'h41);
		put_char(8'h7F);
		put_char(8'hFF);
		read_cell(3);
		stop_sending();
	endtask

	task automatic test_controls();
		put_char(CHAR_BS);
		put_char(CHAR_CR);
		// backspace stops at the left margin
		put_char(CHAR_BS);
		put_char(CHAR_TAB);
		put_char(8'h00);
		put_char(8'h1F);
		put_char(CHAR_LF);
		stop_sending();
	endtask

	task automatic test_tab_wrap();
		repeat (COLUMNS / TAB_STOP) put_char(CHAR_TAB);
		stop_sending();
	endtask

	task automatic send_random(int count);
		int sel;
		repeat (count) begin
			sel = $urandom_range(99);
			if (sel < 20)
				read_cell(IDX_W'($urandom_range(IDX_MAX)));
			else if (sel < 25)
				put_char(CHAR_LF);
			else if (sel < 27)
				put_char(CHAR_CR);
			else if (sel < 30)
				put_char(CHAR_BS);
			else if (sel < 33)
				put_char(CHAR_TAB);
			else if (sel < 39)
				put_char(CHAR_W'($urandom_range(8'h1F)));
			else
				put_char(CHAR_W'($urandom_range(8'hFF, CHAR_BLANK)));
		end
		stop_sending();
	endtask

	task automatic test_random_phases();
		set_colors(4'h0, 4'hF);
		set_idling(0, 0);
		send_random(RANDOM_ITEMS);
		set_colors(4'hF, 4'hF);
		set_idling(69, 0);
		send_random(RANDOM_ITEMS);
		set_colors(4'h0, 4'h0);
		set_idling(0, 69);
		send_random(RANDOM_ITEMS);
		set_colors(COLOR_W'($urandom), COLOR_W'($urandom));
		set_idling(11, 11);
		send_random(RANDOM_ITEMS);
	endtask

	task automatic test_backpressure();
		set_colors(FG_RESET, BG_RESET);
		set_idling(0, 0);
		// results blocked while requests keep coming
		hold_len = HOLD_CYCLES;
		send_random(40);
	endtask

	task automatic test_drain_pause();
		set_idling(11, 11);
		send_random(30);
		while (predicted_rsp.size() != 0)
			@(negedge clk);
		send_random(30);
	endtask

	initial begin
		int k;
		for (k = 0; k < CELLS; k++)
			screen_model[k] = RESET_CELL;
		col_model = 0;
		row_model = 0;
		fg_model = FG_RESET;
		bg_model = BG_RESET;
		mismatch_count = 0;
		hold_len = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.op = OP_PUT;
		req_if.char_code = '0;
		req_if.cell_index = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_FG;
		cfg_if.data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_reg(CFG_FG, FG_RESET);
		write_reg(CFG_BG, BG_RESET);
		test_reset_screen();
		test_printables();
		test_controls();
		test_tab_wrap();
		test_random_phases();
		test_backpressure();
		test_drain_pause();

		while (predicted_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
